@@ rtl/bdq_pkg.sv @@
package bdq_pkg;

    localparam int DATA_W    = 32;
    localparam int FUNC_W    = 3;
    localparam int STAT_W    = 2;
    localparam int DEPTH_DEF = 16;

    localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_LIST       = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] STAT_POP_EMPTY = 2'd3;

endpackage

@@ rtl/bdq_ring_ram.sv @@
module bdq_ring_ram
    import bdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int IDX_W = $clog2(DEPTH)
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [IDX_W-1:0]         wr_addr,
    input  logic signed [DATA_W-1:0] wr_data,
    input  logic                     rd_en,
    input  logic [IDX_W-1:0]         rd_addr,
    output logic signed [DATA_W-1:0] rd_data
);

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/bounded_deque_ring_core.sv @@
// bounded double-ended queue of signed 32-bit values in a ring of DEPTH entries
//
// input channel (in_valid / in_ready, fields func and value): one operation per
// transfer: push front, push back, pop front, pop back or list only (codes 5..7
// also list only). the queue is updated in the cycle of the transfer.
// output channel (out_valid / out_ready, fields element, is_last, status): after
// each operation the contents go out front to back, one transfer per element,
// is_last on the final one; an empty queue gives one zero element.
// every result of one operation carries the same status.
//
// out_valid rises after the input transfer, once the listing state is entered and
// the output slot is free. elements are read one per cycle while the receiver does
// not stall, through the single read port of the ring memory, whose registered
// read data is the output register itself.
// in_ready is low while a listing is in progress; the next item may be taken
// while the final result still waits to be taken.
// a receiver stall holds the current result and pauses the listing.
// reset empties the queue (front and occupancy cleared); memory is not cleared.
module bounded_deque_ring_core
    import bdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [FUNC_W-1:0]        func,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] element,
    output logic                     is_last,
    output logic [STAT_W-1:0]        status
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = IDX_W + 1;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_LIST = 1'b1;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic                state_reg, state_next;
    logic [IDX_W-1:0]    front_reg, front_next;
    logic [CNT_W-1:0]    occ_reg, occ_next;
    logic [STAT_W-1:0]   op_stat_reg, op_stat_next;
    logic [IDX_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    remain_reg, remain_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_last_reg, out_last_next;
    logic                out_zero_reg, out_zero_next;
    logic [STAT_W-1:0]   out_stat_reg, out_stat_next;

    logic                in_xfer;
    logic                slot_free;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic                rd_en;
    logic [IDX_W-1:0]    front_dec;
    logic [IDX_W-1:0]    front_inc;
    logic [SUM_W-1:0]    back_sum;
    logic [IDX_W-1:0]    back_slot;
    logic [STAT_W-1:0]   stat_op;
    logic signed [DATA_W-1:0] rd_data;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    assign front_dec = (front_reg == '0) ? LAST_IDX : front_reg - IDX_W'(1);
    assign front_inc = (front_reg == LAST_IDX) ? '0 : front_reg + IDX_W'(1);

    // slot just past the back; front is below DEPTH and occupancy at most DEPTH here
    assign back_sum  = SUM_W'(front_reg) + SUM_W'(occ_reg);
    assign back_slot = (back_sum >= SUM_W'(DEPTH)) ?
                       IDX_W'(back_sum - SUM_W'(DEPTH)) : IDX_W'(back_sum);

    // queue update at the input transfer
    always_comb
    begin
        front_next = front_reg;
        occ_next   = occ_reg;
        stat_op    = STAT_OK;
        wr_en      = 1'b0;
        wr_addr    = back_slot;
        if (in_xfer)
        begin
            unique case (func)
                FUNC_PUSH_FRONT:
                begin
                    if (occ_reg == FULL_CNT)
                    begin
                        stat_op = STAT_FULL;
                    end
                    else
                    begin
                        front_next = front_dec;
                        wr_addr    = front_dec;
                        wr_en      = 1'b1;
                        occ_next   = occ_reg + CNT_W'(1);
                    end
                end
                FUNC_PUSH_BACK:
                begin
                    if (occ_reg == FULL_CNT)
                    begin
                        stat_op = STAT_FULL;
                    end
                    else
                    begin
                        wr_en    = 1'b1;
                        occ_next = occ_reg + CNT_W'(1);
                    end
                end
                FUNC_POP_FRONT:
                begin
                    if (occ_reg == '0)
                    begin
                        stat_op = STAT_POP_EMPTY;
                    end
                    else
                    begin
                        front_next = front_inc;
                        occ_next   = occ_reg - CNT_W'(1);
                    end
                end
                FUNC_POP_BACK:
                begin
                    if (occ_reg == '0)
                    begin
                        stat_op = STAT_POP_EMPTY;
                    end
                    else
                    begin
                        occ_next = occ_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    stat_op = STAT_OK;
                end
            endcase
        end
    end

    // listing sequencer
    always_comb
    begin
        state_next     = state_reg;
        op_stat_next   = op_stat_reg;
        rd_ptr_next    = rd_ptr_reg;
        remain_next    = remain_reg;
        out_valid_next = out_valid_reg;
        out_last_next  = out_last_reg;
        out_zero_next  = out_zero_reg;
        out_stat_next  = out_stat_reg;
        rd_en          = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next   = S_LIST;
                    rd_ptr_next  = front_next;
                    remain_next  = occ_next;
                    op_stat_next = (stat_op == STAT_OK && occ_next == '0) ?
                                   STAT_EMPTY : stat_op;
                end
            end
            S_LIST:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_stat_next  = op_stat_reg;
                    if (remain_reg == '0)
                    begin
                        out_zero_next = 1'b1;
                        out_last_next = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        rd_en         = 1'b1;
                        out_zero_next = 1'b0;
                        out_last_next = (remain_reg == CNT_W'(1));
                        remain_next   = remain_reg - CNT_W'(1);
                        rd_ptr_next   = (rd_ptr_reg == LAST_IDX) ? '0 :
                                        rd_ptr_reg + IDX_W'(1);
                        if (remain_reg == CNT_W'(1))
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_stat_reg  <= op_stat_next;
        rd_ptr_reg   <= rd_ptr_next;
        remain_reg   <= remain_next;
        out_last_reg <= out_last_next;
        out_zero_reg <= out_zero_next;
        out_stat_reg <= out_stat_next;
    end

    bdq_ring_ram #(
        .DEPTH(DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (value),
        .rd_en   (rd_en),
        .rd_addr (rd_ptr_reg),
        .rd_data (rd_data)
    );

    assign out_valid = out_valid_reg;
    assign element   = out_zero_reg ? '0 : rd_data;
    assign is_last   = out_last_reg;
    assign status    = out_stat_reg;

endmodule

@@ rtl/bdq_checker.sv @@
module bdq_assertions
    import bdq_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic signed [DATA_W-1:0] element,
    input logic                     is_last,
    input logic [STAT_W-1:0]        status
);

    // an empty report is a single zero result
    a_empty_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STAT_EMPTY || status == STAT_POP_EMPTY)
        |-> is_last && element == '0)
        else $error("empty report not a single zero result");

    // the block is busy listing right after taking an item
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item taken while previous listing not started");

    // no new item while a listing is still unfinished
    a_busy_mid_list: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_last |-> !in_ready)
        else $error("item taken in the middle of a listing");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(element)
        && $stable(is_last) && $stable(status))
        else $error("result changed while stalled");

endmodule

bind bounded_deque_ring_core bdq_assertions u_bdq_checker (.*);
